### src/bmff_pkg.sv
// Shared types and fixed field widths for the bitmap with find-first block.
// No dependencies; imported by bitmap_with_find_first.
`default_nettype none

package bmff_pkg;

	localparam int OP_W      = 3;
	localparam int IDX_W     = 10;
	localparam int CFG_W     = 11;
	// signed offset of an index or the size against the current word base
	localparam int REL_W     = 12;
	localparam int BASE_W    = 11;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_SET    = 3'd0,
		OP_CLR    = 3'd1,
		OP_TEST   = 3'd2,
		OP_FSET   = 3'd3,
		OP_FCLR   = 3'd4,
		OP_CLRALL = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### src/bitmap_with_find_first.sv
// Bitmap with set/clear/test, find-first-set, find-first-clear and clear-all; needs bmff_pkg.
// Flow: index errors and undefined opcodes go straight from the beat to the result;
//   set/clear/test scan up to the word holding the index; searches scan until a hit or
//   the last word under the size; clear-all writes every word. One word per cycle.
// One item at a time: s_tready is back the cycle after the result loads into m_tdata.
// Reset: a clearing pass over every word zeroes the store; s_tready is low.
`default_nettype none

module bitmap_with_find_first
	import bmff_pkg::*;
#(
	parameter int NBITS     = 1024,
	parameter int WORD_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_W-1:0]      cfg_wdata,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// [2:0] opcode, [12:3] bit_index, [15:13] zero
	input  wire [S_TDATA_W-1:0]  s_tdata,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	// [0] bit_value, [1] found, [11:2] found_index, [12] index_error, [15:13] zero
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int NWORDS = (NBITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int WBW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [WA-1:0]            LAST_ADDR = WA'(NWORDS - 1);
	localparam logic signed [REL_W-1:0]  WB_S      = REL_W'(WORD_BITS);

	state_t state_q, state_d;

	logic [CFG_W-1:0]           cfg_q;
	logic [CFG_W-1:0]           size_eff;
	op_t                        in_op;
	logic [IDX_W-1:0]           in_idx;
	logic                       in_err;
	logic                       in_undef;

	op_t                        op_q;
	logic                       pend_q;
	logic [WA-1:0]              addr_q, addr_d;
	logic [BASE_W-1:0]          base_q;
	logic signed [REL_W-1:0]    rel_idx_q, rel_size_q;

	logic [WORD_BITS-1:0]       mem [NWORDS];
	logic [WORD_BITS-1:0]       rd_data_q;
	logic                       mem_we;
	logic [WA-1:0]              mem_wa;
	logic [WORD_BITS-1:0]       mem_wd;

	logic [WORD_BITS-1:0]       search_mask, cand;
	logic                       any_hit, in_word, last_word;
	logic [WBW-1:0]             first_pos, bit_pos;

	logic                       res_bv_q, res_fnd_q, res_err_q;
	logic [IDX_W-1:0]           res_fidx_q;
	logic                       out_bv_q, out_fnd_q, out_err_q;
	logic [IDX_W-1:0]           out_fidx_q;
	logic                       m_tvalid_q;
	logic                       out_load;

	assign in_op    = op_t'(s_tdata[OP_W-1:0]);
	assign in_idx   = s_tdata[OP_W+IDX_W-1:OP_W];
	assign size_eff = (32'(cfg_q) > 32'(NBITS)) ? CFG_W'(NBITS) : cfg_q;
	assign in_err   = (in_op == OP_SET || in_op == OP_CLR || in_op == OP_TEST ||
	                   in_op == OP_FSET) && ({1'b0, in_idx} >= size_eff);
	assign in_undef = !(in_op == OP_SET || in_op == OP_CLR || in_op == OP_TEST ||
	                    in_op == OP_FSET || in_op == OP_FCLR || in_op == OP_CLRALL);

	// word evaluation: bits below the size and, for find-first-set, at or after the start index
	always_comb begin
		search_mask = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			search_mask[p] = ($signed(REL_W'(p)) < rel_size_q) &&
			                 ((op_q != OP_FSET) || ($signed(REL_W'(p)) >= rel_idx_q));
		end
		cand    = ((op_q == OP_FSET) ? rd_data_q : ~rd_data_q) & search_mask;
		any_hit = |cand;
		first_pos = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (cand[p]) first_pos = WBW'(p);
		end
		in_word   = rel_idx_q < WB_S;
		last_word = rel_size_q <= WB_S;
		bit_pos   = rel_idx_q[WBW-1:0];
	end

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == LAST_ADDR) state_d = pend_q ? ST_DONE : ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_err || in_undef) state_d = ST_DONE;
					else if (in_op == OP_CLRALL) state_d = ST_CLEAR;
					else state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				case (op_q)
					OP_SET, OP_CLR, OP_TEST: begin
						if (in_word) state_d = ST_DONE;
					end
					OP_FSET, OP_FCLR: begin
						if (any_hit || last_word) state_d = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, memory write and the read address
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = addr_q;
		mem_wd   = rd_data_q;
		addr_d   = addr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wd = '0;
				addr_d = (addr_q == LAST_ADDR) ? '0 : addr_q + WA'(1);
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				addr_d   = '0;
			end
			ST_SCAN: begin
				if ((op_q == OP_SET || op_q == OP_CLR) && in_word) begin
					mem_we = 1'b1;
					if (op_q == OP_SET) mem_wd = rd_data_q | (WORD_BITS'(1) << bit_pos);
					else mem_wd = rd_data_q & ~(WORD_BITS'(1) << bit_pos);
				end
				if (state_d == ST_SCAN) addr_d = addr_q + WA'(1);
			end
			ST_DONE: begin
				addr_d = '0;
			end
			default: begin
				addr_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			pend_q     <= 1'b0;
			cfg_q      <= CFG_W'(1024);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			if (cfg_we) cfg_q <= cfg_wdata;
			if (state_q == ST_IDLE && s_tvalid) pend_q <= (in_op == OP_CLRALL) && !in_err;
			else if (state_q == ST_DONE) pend_q <= 1'b0;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_q <= mem[addr_d];
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q       <= in_op;
			base_q     <= '0;
			rel_idx_q  <= $signed(REL_W'(in_idx));
			rel_size_q <= $signed(REL_W'(size_eff));
			res_bv_q   <= 1'b0;
			res_fnd_q  <= 1'b0;
			res_fidx_q <= '0;
			res_err_q  <= in_err;
		end else if (state_q == ST_SCAN) begin
			base_q     <= base_q + BASE_W'(WORD_BITS);
			rel_idx_q  <= rel_idx_q - WB_S;
			rel_size_q <= rel_size_q - WB_S;
			if (op_q == OP_TEST && in_word) res_bv_q <= rd_data_q[bit_pos];
			if ((op_q == OP_FSET || op_q == OP_FCLR) && any_hit) begin
				res_fnd_q  <= 1'b1;
				res_fidx_q <= IDX_W'(base_q + BASE_W'(first_pos));
			end
		end
		if (out_load) begin
			out_bv_q   <= res_bv_q;
			out_fnd_q  <= res_fnd_q;
			out_fidx_q <= res_fidx_q;
			out_err_q  <= res_err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_err_q, out_fidx_q, out_fnd_q, out_bv_q};

	// a bit access never scans past the word holding its index
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && (op_q == OP_SET || op_q == OP_CLR || op_q == OP_TEST))
		|-> !rel_idx_q[REL_W-1])
		else $error("bit access scanned past its word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= LAST_ADDR))
		else $error("scan address beyond store");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && mem_we) |-> (op_q == OP_SET || op_q == OP_CLR))
		else $error("store written by a read-only opcode");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_err_q) |-> (!out_fnd_q && !out_bv_q && out_fidx_q == '0))
		else $error("error result carries other fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && state_d == ST_DONE && any_hit &&
		 (op_q == OP_FSET || op_q == OP_FCLR))
		|-> ($signed(REL_W'(first_pos)) < rel_size_q))
		else $error("search hit beyond size");

endmodule

`default_nettype wire
